>>> hw/rtl/json_stream_indenter_core_assert.svh
// Assertion macros shared by the checker of the indenter core.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef JSON_STREAM_INDENTER_CORE_ASSERT_SVH
`define JSON_STREAM_INDENTER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define JSIC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JSIC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/jsic_pkg.sv
// Package for the JSON stream indenter: character codes, widths and the
// request descriptor passed from the parser to the byte emitter. No dependencies.
package jsic_pkg;

	localparam int LEVEL_W     = 3;
	localparam int MAX_LEVEL_D = 7;
	localparam int WIDTH_W     = 3;
	localparam logic [WIDTH_W-1:0] INDENT_RESET = 3'd4;
	localparam logic [WIDTH_W-1:0] INDENT_CAP   = 3'd4;
	localparam int SPACE_W     = $clog2(MAX_LEVEL_D * 4 + 1);

	localparam logic [7:0] SKIP_LIMIT = 8'd32;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_COLON   = 8'h3A;

	typedef struct packed {
		logic               pre_ind;   // newline and indent before the body
		logic               post_ind;  // newline and indent after the body
		logic               colon;     // body is space, colon, space
		logic [7:0]         body;
		logic [SPACE_W-1:0] spaces;
		logic               err;
	} jsic_job_t;

endpackage

>>> hw/rtl/json_stream_indenter_core.sv
// JSON stream indenter, top level: parser state and request decode, with the
// byte emitter below. Depends on jsic_pkg and jsic_emitter.
// The request is registered into the emitter state, then each output byte into
// the output register. A kept byte gives 1 to 59 output bytes; input is held
// off meanwhile; the space down-counter gives one byte a cycle unless stalled.
// Reset (arst_n low): level 0, no pending open, outside string, indent width 4.
module json_stream_indenter_core
	import jsic_pkg::*;
#(
	parameter int MAX_LEVEL = MAX_LEVEL_D
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         text_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               nest_error,
	input  logic               cfg_we,
	input  logic [WIDTH_W-1:0] cfg_wdata
);

	logic [WIDTH_W-1:0] width_q;
	logic [LEVEL_W-1:0] level_q;
	logic               open_q;
	logic               str_q;
	logic               esc_q;

	logic               busy;
	logic               acc;
	logic               kept;
	logic               is_open;
	logic               is_close;
	logic               pre_ind;
	logic               close_ind;
	logic               err;
	logic [LEVEL_W-1:0] level_d;
	logic [WIDTH_W-1:0] width_sat;
	logic [LEVEL_W+WIDTH_W-1:0] prod;
	jsic_job_t          job;

	// Hold input off while a request is still being expanded.
	assign in_stall = busy;
	assign acc      = in_valid && !in_stall;

	assign is_open  = (text_byte inside {CH_LBRACE, CH_LBRACK});
	assign is_close = (text_byte inside {CH_RBRACE, CH_RBRACK});

	// Outside a string, control bytes and space are dropped.
	assign kept      = str_q || (text_byte > SKIP_LIMIT);
	// Pending open followed by anything but a close: descend one level first.
	assign pre_ind   = !str_q && open_q && !is_close;
	// Close without a pending open: ascend and start a new line.
	assign close_ind = !str_q && is_close && !open_q;

	always_comb begin
		level_d = level_q;
		err     = 1'b0;
		if (pre_ind) begin
			if (level_q >= LEVEL_W'(MAX_LEVEL)) begin
				err = 1'b1;
			end else begin
				level_d = level_q + 1'b1;
			end
		end else if (close_ind) begin
			if (level_q == '0) begin
				err = 1'b1;
			end else begin
				level_d = level_q - 1'b1;
			end
		end
	end

	// Widths above the cap saturate; zero gives bare newlines.
	assign width_sat = (width_q > INDENT_CAP) ? INDENT_CAP : width_q;
	assign prod      = {{WIDTH_W{1'b0}}, level_d} * {{LEVEL_W{1'b0}}, width_sat};

	always_comb begin
		job.pre_ind  = pre_ind || close_ind;
		job.post_ind = !str_q && (text_byte == CH_COMMA);
		job.colon    = !str_q && (text_byte == CH_COLON);
		job.body     = text_byte;
		job.spaces   = prod[SPACE_W-1:0];
		job.err      = err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= INDENT_RESET;
			level_q <= '0;
			open_q  <= 1'b0;
			str_q   <= 1'b0;
			esc_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				width_q <= cfg_wdata;
			end
			if (acc && kept) begin
				if (str_q) begin
					// Escaped pair passes through; an unescaped quote ends the string.
					if (esc_q) begin
						esc_q <= 1'b0;
					end else if (text_byte == CH_BSLASH) begin
						esc_q <= 1'b1;
					end else if (text_byte == CH_QUOTE) begin
						str_q <= 1'b0;
					end
				end else begin
					level_q <= level_d;
					open_q  <= is_open;
					if (text_byte == CH_QUOTE) begin
						str_q <= 1'b1;
						esc_q <= 1'b0;
					end
				end
			end
		end
	end

	jsic_emitter u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (acc && kept),
		.job        (job),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.nest_error (nest_error)
	);

endmodule

>>> hw/rtl/jsic_emitter.sv
// Byte emitter: sequences one request into output bytes through a shared
// space down-counter and an output register. Depends on jsic_pkg.
module jsic_emitter
	import jsic_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  jsic_job_t job,
	output logic      busy,
	output logic      out_valid,
	input  logic      out_stall,
	output logic [7:0] out_byte,
	output logic      run_last,
	output logic      nest_error
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_NL_PRE  = 3'd1;
	localparam logic [2:0] ST_SP_PRE  = 3'd2;
	localparam logic [2:0] ST_BODY    = 3'd3;
	localparam logic [2:0] ST_NL_POST = 3'd4;
	localparam logic [2:0] ST_SP_POST = 3'd5;

	logic [2:0]         st_q;
	logic [2:0]         st_d;
	logic [SPACE_W-1:0] cnt_q;
	logic [SPACE_W-1:0] cnt_d;
	logic [1:0]         idx_q;
	logic [1:0]         idx_d;
	logic               post_q;
	logic               colon_q;
	logic [7:0]         body_q;
	logic [SPACE_W-1:0] spaces_q;
	logic               err_q;
	logic               ov_q;
	logic [7:0]         ob_q;
	logic               last_q;
	logic               oerr_q;
	logic               slot_free;
	logic               fire;
	logic [7:0]         byte_d;
	logic               last_d;

	assign busy      = (st_q != ST_IDLE);
	assign slot_free = !ov_q || !out_stall;
	assign fire      = busy && slot_free;

	always_comb begin
		st_d   = st_q;
		cnt_d  = cnt_q;
		idx_d  = idx_q;
		byte_d = CH_SPACE;
		last_d = 1'b0;
		case (st_q)
			ST_NL_PRE: begin
				byte_d = CH_NL;
				cnt_d  = spaces_q;
				st_d   = (spaces_q != '0) ? ST_SP_PRE : ST_BODY;
			end
			ST_SP_PRE: begin
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == SPACE_W'(1)) begin
					st_d = ST_BODY;
				end
			end
			ST_BODY: begin
				if (colon_q) begin
					byte_d = (idx_q == 2'd1) ? CH_COLON : CH_SPACE;
				end else begin
					byte_d = body_q;
				end
				idx_d = idx_q + 1'b1;
				if (!colon_q || idx_q == 2'd2) begin
					if (post_q) begin
						st_d = ST_NL_POST;
					end else begin
						st_d   = ST_IDLE;
						last_d = 1'b1;
					end
				end
			end
			ST_NL_POST: begin
				byte_d = CH_NL;
				cnt_d  = spaces_q;
				if (spaces_q != '0) begin
					st_d = ST_SP_POST;
				end else begin
					st_d   = ST_IDLE;
					last_d = 1'b1;
				end
			end
			ST_SP_POST: begin
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == SPACE_W'(1)) begin
					st_d   = ST_IDLE;
					last_d = 1'b1;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				st_q <= job.pre_ind ? ST_NL_PRE : ST_BODY;
			end else if (fire) begin
				st_q <= st_d;
			end
			if (fire) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			post_q   <= job.post_ind;
			colon_q  <= job.colon;
			body_q   <= job.body;
			spaces_q <= job.spaces;
			err_q    <= job.err;
			idx_q    <= '0;
			cnt_q    <= '0;
		end else if (fire) begin
			idx_q <= idx_d;
			cnt_q <= cnt_d;
		end
		if (fire) begin
			ob_q   <= byte_d;
			last_q <= last_d;
			oerr_q <= err_q;
		end
	end

	assign out_valid  = ov_q;
	assign out_byte   = ob_q;
	assign run_last   = last_q;
	assign nest_error = oerr_q;

endmodule

>>> hw/rtl/jsic_checker.sv
// Port-level checker for the JSON stream indenter core, bound to the top level.
// Depends on jsic_pkg and json_stream_indenter_core_assert.svh.
`include "json_stream_indenter_core_assert.svh"

module jsic_checker
	import jsic_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       nest_error
);

	logic       out_take;
	logic       nl_mid;
	logic [9:0] out_word;

	assign out_take = out_valid && !out_stall;
	assign nl_mid   = out_take && (out_byte == CH_NL) && !run_last;
	assign out_word = {out_byte, run_last, nest_error};

	// A stalled result holds its payload.
	`JSIC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")

	// Input stays stalled until the last byte of a run is shown.
	`JSIC_ASSERT_NOW(a_run_blocks_in, out_valid && !run_last, in_stall, "input taken mid-run")

	// A run continues without gaps and keeps one error flag.
	`JSIC_ASSERT_NEXT(a_run_err_const, out_take && !run_last, out_valid && $stable(nest_error), "run broken")

	// A newline inside a run is followed by indentation or text, never another newline.
	`JSIC_ASSERT_NEXT(a_nl_then_more, nl_mid, out_valid && (out_byte != CH_NL), "newline after newline")

endmodule

bind json_stream_indenter_core jsic_checker u_jsic_checker (.*);
